/* src/pese_pkg.sv */
// Package: shared constants, types and codes of the prefix expression evaluator.
`timescale 1ns / 1ps
package pese_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int VALUE_W       = 32;
  localparam int STACK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W          = $clog2(STACK_DEPTH + 1);
  // divider numerator width: magnitude of A scaled by 2^FRACTION_BITS
  localparam int NUM_W         = VALUE_W + FRACTION_BITS;
  localparam int CNT_W         = $clog2(NUM_W + 1);

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_DIVZERO   = 3'd3,
    ERR_UNKNOWN   = 3'd4
  } err_t;

  localparam logic [7:0] SYM_ZERO = 8'd48;
  localparam logic [7:0] SYM_NINE = 8'd57;
  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_MOD  = 8'h25;

  // operator class the controller branches on
  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIVMOD
  } sym_class_t;

  // datapath commands, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_POPA,
    CMD_POPB,
    CMD_EXEC,
    CMD_MULFIX,
    CMD_DIVSTEP,
    CMD_DIVFIX,
    CMD_PUSH,
    CMD_TOP,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic       in_digit;
    sym_class_t sym_class;
    logic       den_zero;
    logic       div_last;
    logic       out_busy;
    logic       final_sym;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POPA,
    S_POPB,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIVFIX,
    S_PUSH,
    S_TOP,
    S_OUT
  } state_t;

endpackage

/* src/prefix_expression_stack_evaluator_top.sv */
// Top level: prefix expression evaluator, controller plus datapath.
//
// Symbol words enter on the in_ stream, last character of the expression
// first; in_tlast marks the expression's first character. Digits push their
// value, operators + - * / % pop two operands and push the result, all in
// signed Q16.16. The word with in_tlast set yields one out_ word holding the
// top of stack and the first error seen, then the stack and error clear.
// Each symbol word is sequenced to the end before the next one is taken;
// divide or modulo runs 48 one-bit steps of the restoring divider.
// A final word adds the top-of-stack read before out_tvalid.
// The result sits in an output register; the next expression's words are
// taken while it waits. If the receiver stalls at the next final word, the
// block holds there until the output register frees.
// Reset (rst_n low, synchronous) empties the stack, clears the error and
// drops out_tvalid; stack RAM contents are not cleared.
`timescale 1ns / 1ps
module prefix_expression_stack_evaluator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // final_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [34:32] error_code, [39:35] zero
);

  pese_pkg::cmd_t    cmd;
  pese_pkg::status_t status;
  pese_pkg::value_t  value;
  logic [2:0]        err;

  pese_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pese_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_symbol (in_tdata),
    .in_final  (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (value),
    .out_err   (err)
  );

  assign out_tdata = {5'b0, err, value};

endmodule

/* src/pese_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pese_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/pese_datapath.sv */
// Datapath: operand stack, arithmetic units, divider, sticky error and output word.
`timescale 1ns / 1ps
module pese_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pese_pkg::cmd_t      cmd,
  output pese_pkg::status_t   status,
  input  logic [7:0]          in_symbol,
  input  logic                in_final,
  output logic                out_valid,
  input  logic                out_ready,
  output pese_pkg::value_t    out_value,
  output logic [2:0]          out_err
);

  localparam int VW = pese_pkg::VALUE_W;
  localparam int FB = pese_pkg::FRACTION_BITS;
  localparam int NW = pese_pkg::NUM_W;

  function automatic pese_pkg::value_t sat64(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sd2147483647;
    vmin = -64'sd2147483648;
    if (v > vmax) begin
      sat64 = 32'sh7FFFFFFF;
    end else if (v < vmin) begin
      sat64 = 32'sh80000000;
    end else begin
      sat64 = v[VW-1:0];
    end
  endfunction

  // registers
  logic [7:0]                    sym_r;
  logic                          final_r;
  logic [pese_pkg::SP_W-1:0]     sp_r, sp_nxt;
  pese_pkg::err_t                err_r, err_nxt;
  pese_pkg::value_t              a_r, result_r;
  logic                          a_zero_r, b_zero_r, top_zero_r;
  logic signed [63:0]            prod_r;
  logic [32:0]                   rem_r;
  logic [NW-1:0]                 quo_r;
  logic [VW-1:0]                 den_r;
  logic [pese_pkg::CNT_W-1:0]    cnt_r;
  logic                          neg_q_r, neg_r_r, is_mod_r;
  logic                          out_valid_r;
  pese_pkg::value_t              out_value_r;
  logic [2:0]                    out_err_r;

  // RAM ports
  logic                          we, re;
  logic [pese_pkg::STACK_AW-1:0] waddr, raddr;
  logic [VW-1:0]                 rdata;

  pese_ram #(.WIDTH(VW), .DEPTH(pese_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (result_r),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // symbol decode
  logic             in_digit;
  logic [3:0]       digit;
  pese_pkg::value_t digit_val;
  pese_pkg::sym_class_t cls;
  logic             known;

  assign in_digit  = (in_symbol >= pese_pkg::SYM_ZERO) && (in_symbol <= pese_pkg::SYM_NINE);
  assign digit     = 4'(in_symbol - pese_pkg::SYM_ZERO);
  assign digit_val = sat64(64'(signed'({1'b0, digit})) <<< FB);

  always_comb begin
    unique case (sym_r)
      pese_pkg::SYM_MUL:                  cls = pese_pkg::CLS_MUL;
      pese_pkg::SYM_DIV, pese_pkg::SYM_MOD: cls = pese_pkg::CLS_DIVMOD;
      default:                            cls = pese_pkg::CLS_SIMPLE;
    endcase
  end
  assign known = (sym_r == pese_pkg::SYM_ADD) || (sym_r == pese_pkg::SYM_SUB) ||
                 (sym_r == pese_pkg::SYM_MUL) || (sym_r == pese_pkg::SYM_DIV) ||
                 (sym_r == pese_pkg::SYM_MOD);

  // operand magnitudes at EXEC
  pese_pkg::value_t b_cur;
  logic [VW-1:0]    a_mag, b_mag, ia_mag, ib_mag;
  logic             den_zero;

  assign b_cur    = b_zero_r ? '0 : pese_pkg::value_t'(rdata);
  assign a_mag    = a_r[VW-1] ? VW'(-a_r) : VW'(a_r);
  assign b_mag    = b_cur[VW-1] ? VW'(-b_cur) : VW'(b_cur);
  assign ia_mag   = a_mag >> FB;
  assign ib_mag   = b_mag >> FB;
  assign den_zero = (sym_r == pese_pkg::SYM_MOD) ? (ib_mag == '0) : (b_cur == '0);

  // one restoring divider step
  logic [32:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_r[31:0], quo_r[NW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  // divider result fix-up
  pese_pkg::value_t div_val;
  logic [VW-1:0]    rem_scaled;
  always_comb begin
    rem_scaled = rem_r[VW-1:0] << FB;
    if (is_mod_r) begin
      div_val = neg_r_r ? pese_pkg::value_t'(-rem_scaled) : pese_pkg::value_t'(rem_scaled);
    end else if (neg_q_r) begin
      if (quo_r > NW'(64'h80000000)) begin
        div_val = 32'sh80000000;
      end else begin
        div_val = pese_pkg::value_t'(-quo_r[VW-1:0]);
      end
    end else if (quo_r > NW'(64'h7FFFFFFF)) begin
      div_val = 32'sh7FFFFFFF;
    end else begin
      div_val = pese_pkg::value_t'(quo_r[VW-1:0]);
    end
  end

  // stack pointer, error flags and RAM control
  pese_pkg::err_t flag;
  always_comb begin
    sp_nxt = sp_r;
    flag   = pese_pkg::ERR_NONE;
    we     = 1'b0;
    re     = 1'b0;
    waddr  = sp_r[pese_pkg::STACK_AW-1:0];
    raddr  = pese_pkg::STACK_AW'(sp_r - 1'b1);
    unique case (cmd)
      pese_pkg::CMD_POPA, pese_pkg::CMD_POPB, pese_pkg::CMD_TOP: begin
        if (sp_r == '0) begin
          flag = pese_pkg::ERR_UNDERFLOW;
        end else begin
          re = 1'b1;
          if (cmd != pese_pkg::CMD_TOP) begin
            sp_nxt = sp_r - 1'b1;
          end
        end
      end
      pese_pkg::CMD_EXEC: begin
        if (!known) begin
          flag = pese_pkg::ERR_UNKNOWN;
        end else if (cls == pese_pkg::CLS_DIVMOD && den_zero) begin
          flag = pese_pkg::ERR_DIVZERO;
        end
      end
      pese_pkg::CMD_PUSH: begin
        if (sp_r >= pese_pkg::SP_W'(pese_pkg::STACK_DEPTH)) begin
          flag = pese_pkg::ERR_OVERFLOW;
        end else begin
          we     = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
      end
      pese_pkg::CMD_EMIT: sp_nxt = '0;
      default: ;
    endcase
    err_nxt = err_r;
    if (cmd == pese_pkg::CMD_EMIT) begin
      err_nxt = pese_pkg::ERR_NONE;
    end else if (err_r == pese_pkg::ERR_NONE) begin
      err_nxt = flag;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      err_r       <= pese_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
      if (cmd == pese_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      pese_pkg::CMD_LOAD: begin
        sym_r    <= in_symbol;
        final_r  <= in_final;
        result_r <= digit_val;
      end
      pese_pkg::CMD_POPA: a_zero_r <= (sp_r == '0);
      pese_pkg::CMD_POPB: begin
        a_r      <= a_zero_r ? '0 : pese_pkg::value_t'(rdata);
        b_zero_r <= (sp_r == '0);
      end
      pese_pkg::CMD_EXEC: begin
        prod_r   <= a_r * b_cur;
        neg_q_r  <= a_r[VW-1] ^ b_cur[VW-1];
        neg_r_r  <= a_r[VW-1];
        is_mod_r <= (sym_r == pese_pkg::SYM_MOD);
        den_r    <= (sym_r == pese_pkg::SYM_MOD) ? ib_mag : b_mag;
        quo_r    <= (sym_r == pese_pkg::SYM_MOD) ? NW'(ia_mag) : (NW'(a_mag) << FB);
        rem_r    <= '0;
        cnt_r    <= pese_pkg::CNT_W'(NW);
        if (sym_r == pese_pkg::SYM_ADD) begin
          result_r <= a_r + b_cur;
        end else if (sym_r == pese_pkg::SYM_SUB) begin
          result_r <= a_r - b_cur;
        end else begin
          result_r <= '0;
        end
      end
      pese_pkg::CMD_MULFIX: result_r <= sat64(prod_r >>> FB);
      pese_pkg::CMD_DIVSTEP: begin
        rem_r <= q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
        quo_r <= {quo_r[NW-2:0], q_bit};
        cnt_r <= cnt_r - 1'b1;
      end
      pese_pkg::CMD_DIVFIX: result_r <= div_val;
      pese_pkg::CMD_TOP: top_zero_r <= (sp_r == '0);
      pese_pkg::CMD_EMIT: begin
        out_value_r <= top_zero_r ? '0 : pese_pkg::value_t'(rdata);
        out_err_r   <= err_r;
      end
      default: ;
    endcase
  end

  assign status.in_digit  = in_digit;
  assign status.sym_class = cls;
  assign status.den_zero  = den_zero;
  assign status.div_last  = (cnt_r == pese_pkg::CNT_W'(1));
  assign status.out_busy  = out_valid_r && !out_ready;
  assign status.final_sym = final_r;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_err   = out_err_r;

endmodule

/* src/pese_controller.sv */
// Controller: state machine that sequences the datapath for each symbol word.
`timescale 1ns / 1ps
module pese_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pese_pkg::status_t status,
  output pese_pkg::cmd_t    cmd
);

  pese_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pese_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pese_pkg::S_IDLE:
        if (in_valid) begin
          state_nxt = status.in_digit ? pese_pkg::S_PUSH : pese_pkg::S_POPA;
        end
      pese_pkg::S_POPA: state_nxt = pese_pkg::S_POPB;
      pese_pkg::S_POPB: state_nxt = pese_pkg::S_EXEC;
      pese_pkg::S_EXEC: begin
        if (status.sym_class == pese_pkg::CLS_MUL) begin
          state_nxt = pese_pkg::S_MUL;
        end else if (status.sym_class == pese_pkg::CLS_DIVMOD && !status.den_zero) begin
          state_nxt = pese_pkg::S_DIV;
        end else begin
          state_nxt = pese_pkg::S_PUSH;
        end
      end
      pese_pkg::S_MUL:    state_nxt = pese_pkg::S_PUSH;
      pese_pkg::S_DIV:    if (status.div_last) state_nxt = pese_pkg::S_DIVFIX;
      pese_pkg::S_DIVFIX: state_nxt = pese_pkg::S_PUSH;
      pese_pkg::S_PUSH:   state_nxt = status.final_sym ? pese_pkg::S_TOP : pese_pkg::S_IDLE;
      pese_pkg::S_TOP:    state_nxt = pese_pkg::S_OUT;
      pese_pkg::S_OUT:    if (!status.out_busy) state_nxt = pese_pkg::S_IDLE;
      default:            state_nxt = pese_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = pese_pkg::CMD_NONE;
    unique case (state_r)
      pese_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = pese_pkg::CMD_LOAD;
      end
      pese_pkg::S_POPA:   cmd = pese_pkg::CMD_POPA;
      pese_pkg::S_POPB:   cmd = pese_pkg::CMD_POPB;
      pese_pkg::S_EXEC:   cmd = pese_pkg::CMD_EXEC;
      pese_pkg::S_MUL:    cmd = pese_pkg::CMD_MULFIX;
      pese_pkg::S_DIV:    cmd = pese_pkg::CMD_DIVSTEP;
      pese_pkg::S_DIVFIX: cmd = pese_pkg::CMD_DIVFIX;
      pese_pkg::S_PUSH:   cmd = pese_pkg::CMD_PUSH;
      pese_pkg::S_TOP:    cmd = pese_pkg::CMD_TOP;
      pese_pkg::S_OUT:    if (!status.out_busy) cmd = pese_pkg::CMD_EMIT;
      default: ;
    endcase
  end

endmodule

/* test/prefix_expression_stack_evaluator_checker.sv */
// Checker: watches the symbol and result streams, predicts expression results, compares.
`timescale 1ns / 1ps
module prefix_expression_stack_evaluator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,   // final_symbol
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] value, [34:32] error_code, [39:35] zero
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic [31:0]     value;
    pese_pkg::err_t  code;
  } expr_result_t;

  pese_pkg::value_t eval_stack [pese_pkg::STACK_DEPTH];
  int               eval_depth;
  pese_pkg::err_t   eval_error;
  expr_result_t     expected_results [$];

  assign pending_results = expected_results.size();

  function automatic void note_error(pese_pkg::err_t e);
    if (eval_error == pese_pkg::ERR_NONE) eval_error = e;
  endfunction

  function automatic longint sat_value(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void push_operand(pese_pkg::value_t v);
    if (eval_depth >= pese_pkg::STACK_DEPTH) note_error(pese_pkg::ERR_OVERFLOW);
    else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  function automatic pese_pkg::value_t pop_operand();
    if (eval_depth == 0) begin
      note_error(pese_pkg::ERR_UNDERFLOW);
      return '0;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  function automatic pese_pkg::value_t apply_operator(logic [7:0] sym, pese_pkg::value_t a,
                                                      pese_pkg::value_t b);
    longint one, prod, ia, ib;
    one = longint'(1) << pese_pkg::FRACTION_BITS;
    case (sym)
      pese_pkg::SYM_ADD: return a + b;
      pese_pkg::SYM_SUB: return a - b;
      pese_pkg::SYM_MUL: begin
        prod = longint'(a) * longint'(b);
        return pese_pkg::value_t'(sat_value(prod >>> pese_pkg::FRACTION_BITS));
      end
      pese_pkg::SYM_DIV: begin
        if (b == 0) begin
          note_error(pese_pkg::ERR_DIVZERO);
          return '0;
        end
        return pese_pkg::value_t'(sat_value((longint'(a) * one) / longint'(b)));
      end
      pese_pkg::SYM_MOD: begin
        ia = longint'(a) / one;
        ib = longint'(b) / one;
        if (ib == 0) begin
          note_error(pese_pkg::ERR_DIVZERO);
          return '0;
        end
        return pese_pkg::value_t'(sat_value((ia % ib) * one));
      end
      default: begin
        note_error(pese_pkg::ERR_UNKNOWN);
        return '0;
      end
    endcase
  endfunction

  // advance the prediction by one accepted symbol word
  function automatic void take_symbol(logic [7:0] sym, logic last);
    pese_pkg::value_t a, b;
    expr_result_t r;
    if (sym >= pese_pkg::SYM_ZERO && sym <= pese_pkg::SYM_NINE)
      push_operand(pese_pkg::value_t'(longint'(sym - pese_pkg::SYM_ZERO)
                                      << pese_pkg::FRACTION_BITS));
    else begin
      a = pop_operand();
      b = pop_operand();
      push_operand(apply_operator(sym, a, b));
    end
    if (last) begin
      if (eval_depth == 0) begin
        note_error(pese_pkg::ERR_UNDERFLOW);
        r.value = '0;
      end else r.value = eval_stack[eval_depth-1];
      r.code = eval_error;
      expected_results.push_back(r);
      eval_depth = 0;
      eval_error = pese_pkg::ERR_NONE;
    end
  endfunction

  always @(posedge clk) begin
    expr_result_t want;
    if (!rst_n) begin
      eval_depth = 0;
      eval_error = pese_pkg::ERR_NONE;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) take_symbol(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.value || out_tdata[34:32] !== want.code
              || out_tdata[39:35] !== 5'd0) begin
            if (fail_count < 10)
              $display("result: expected value %h err %0d, got value %h err %0d",
                       want.value, want.code, out_tdata[31:0], out_tdata[34:32]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* test/tb_prefix_expression_stack_evaluator_top.sv */
// Testbench top: drives symbol words with random gaps and back-pressure, gives the verdict.
`timescale 1ns / 1ps
module tb_prefix_expression_stack_evaluator_top;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] symbol
  logic        in_tlast;   // final_symbol
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] value, [34:32] error_code, [39:35] zero
  int          fail_count;
  int          pending_results;
  int          cycle_count;
  int          words_sent;
  bit          quiet_phase;
  bit          hold_receiver;

  prefix_expression_stack_evaluator_top uut (.*);

  prefix_expression_stack_evaluator_checker expr_check (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("prefix_expression_stack_evaluator_top: mismatch");
      $finish;
    end
  end

  // receiver: random stalls in bursts, long hold when requested
  initial begin
    int burst;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_receiver) begin
        out_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_receiver = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 8);
        out_tready <= 0;
        repeat (burst) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  // send one symbol word, waiting for acceptance
  task automatic send_symbol(logic [7:0] sym, logic last);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= sym;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0: return pese_pkg::SYM_ADD;
      1: return pese_pkg::SYM_SUB;
      2: return pese_pkg::SYM_MUL;
      3: return pese_pkg::SYM_DIV;
      default: return pese_pkg::SYM_MOD;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return pese_pkg::SYM_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // well-formed prefix expression, built in reverse: operands and operators interleaved
  task automatic send_expression(int ops);
    int need, depth, total, i;
    logic last;
    need  = ops + 1;
    depth = 0;
    total = 2 * ops + 1;
    for (i = 0; i < total; i++) begin
      last = (i == total - 1);
      // an operator needs two operands already on the stack
      if (need > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
        send_symbol(pick_digit(), last);
        need--;
        depth++;
      end else begin
        send_symbol(pick_operator(), last);
        depth--;
      end
    end
  endtask

  initial begin
    logic [7:0] sym;
    int n, k;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    quiet_phase = 0;
    hold_receiver = 0;
    words_sent = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: each operator, zero divisors, unknown, empty stack
    send_symbol(pese_pkg::SYM_ZERO + 8'd9, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd3, 0);
    send_symbol(pese_pkg::SYM_ADD, 1);
    send_symbol(pese_pkg::SYM_ZERO + 8'd9, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd3, 0);
    send_symbol(pese_pkg::SYM_SUB, 1);
    send_symbol(pese_pkg::SYM_ZERO + 8'd7, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd9, 0);
    send_symbol(pese_pkg::SYM_MUL, 1);
    send_symbol(pese_pkg::SYM_ZERO + 8'd7, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd2, 0);
    send_symbol(pese_pkg::SYM_DIV, 1);
    send_symbol(pese_pkg::SYM_ZERO, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd5, 0);
    send_symbol(pese_pkg::SYM_DIV, 1);
    send_symbol(pese_pkg::SYM_ZERO + 8'd4, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd9, 0);
    send_symbol(pese_pkg::SYM_MOD, 1);
    send_symbol(pese_pkg::SYM_ZERO + 8'd4, 0); send_symbol(pese_pkg::SYM_DIV, 0);
    send_symbol(pese_pkg::SYM_MOD, 1);
    send_symbol(8'hFF, 1);
    send_symbol(8'h00, 1);
    send_symbol(pese_pkg::SYM_ZERO + 8'd1, 0); send_symbol(pese_pkg::SYM_ZERO + 8'd2, 1);

    // fill past stack depth, then saturate large products and quotients
    for (k = 0; k < pese_pkg::STACK_DEPTH + 2; k++) send_symbol(pese_pkg::SYM_ZERO + 8'd9, 0);
    for (k = 0; k < 12; k++) send_symbol(pese_pkg::SYM_MUL, 0);
    send_symbol(pese_pkg::SYM_DIV, 1);

    // pause until everything has drained
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    // long receiver hold while the sender keeps going
    hold_receiver = 1;
    for (k = 0; k < 20; k++) send_expression(1);

    // random: mostly well-formed expressions, some noise
    while (words_sent < 1550) begin
      if (words_sent > 1350) quiet_phase = 1;
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          sym = 8'($urandom_range(0, 255));
          send_symbol(sym, $urandom_range(0, 3) == 0);
        end
      end else begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
        send_expression(n);
      end
    end
    in_tvalid <= 0;

    // drain
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("prefix_expression_stack_evaluator_top: match");
    else $display("prefix_expression_stack_evaluator_top: mismatch");
    $finish;
  end

endmodule
